/* design/fragment_frame_checker_unit_assert.svh */
// assertion macros for the frame checker
`ifndef FRAGMENT_FRAME_CHECKER_UNIT_ASSERT_SVH
`define FRAGMENT_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define FFC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffc assertion failed");

// next-cycle implication
`define FFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffc assertion failed");

`endif

/* design/ffc_pkg.sv */
package ffc_pkg;

    localparam int unsigned HEADER_BYTES = 10;
    localparam int unsigned MARKER_LEN = 6;
    localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [16:0] POS_MAX = 17'h1FFFF;
    localparam logic [15:0] PAYLOAD_LENGTH_RESET = 16'd64;

    localparam logic [15:0] TYPE_DATA = 16'h3131;
    localparam logic [15:0] TYPE_DATA_END = 16'h3130;
    localparam logic [15:0] TYPE_END_CONN = 16'h3030;
    localparam logic [15:0] TYPE_KEEPALIVE = 16'h3031;

    localparam logic [2:0] VERDICT_ACK = 3'd0;
    localparam logic [2:0] VERDICT_RESEND = 3'd1;
    localparam logic [2:0] VERDICT_FILE_START = 3'd2;
    localparam logic [2:0] VERDICT_END_DATA = 3'd3;
    localparam logic [2:0] VERDICT_END_CONN = 3'd4;
    localparam logic [2:0] VERDICT_KEEPALIVE = 3'd5;
    localparam logic [2:0] VERDICT_BAD_HEADER = 3'd6;
    localparam logic [2:0] VERDICT_BAD_LENGTH = 3'd7;

    localparam logic REG_PAYLOAD_LENGTH = 1'b0;

    typedef struct packed {
        logic [15:0] type_chars;
        logic [31:0] number;
        logic [31:0] checksum;
        logic [31:0] crc;
        logic        len_short;
        logic        len_ok;
        logic        marker_ok;
    } ffc_frame_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] marker_byte(input logic [2:0] idx);
        logic [7:0] m;
        unique case (idx)
            3'd0: m = 8'h21;
            3'd1: m = 8'h66;
            3'd2: m = 8'h69;
            3'd3: m = 8'h6C;
            3'd4: m = 8'h65;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

/* design/ffc_front.sv */
module ffc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             frame_byte,
    input  logic                   frame_end,
    input  logic [15:0]            payload_length,
    output logic                   push,
    output ffc_pkg::ffc_frame_t    push_data
);

    logic [16:0] pos_reg, pos_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] crc_reg, crc_next;
    logic        match_reg, match_next;
    logic        take;
    logic [16:0] p;
    logic [1:0]  lane;
    logic [17:0] len;
    logic [17:0] len_expected;

    assign take = in_valid && in_ready;
    assign p = pos_reg - 17'(ffc_pkg::HEADER_BYTES);
    assign len = {1'b0, pos_reg} + 18'd1;
    assign len_expected = 18'(ffc_pkg::HEADER_BYTES) + {2'b0, payload_length};

    always_comb
    begin
        pos_next = pos_reg;
        type_next = type_reg;
        num_next = num_reg;
        sum_next = sum_reg;
        crc_next = crc_reg;
        match_next = match_reg;
        lane = 2'd0;
        if (take)
        begin
            priority if (pos_reg < 17'd2)
            begin
                type_next = {type_reg[7:0], frame_byte};
            end
            else if (pos_reg < 17'd6)
            begin
                lane = 2'(pos_reg - 17'd2);
                num_next[{lane, 3'b000} +: 8] = frame_byte;
            end
            else if (pos_reg < 17'(ffc_pkg::HEADER_BYTES))
            begin
                lane = 2'(pos_reg - 17'd6);
                sum_next[{lane, 3'b000} +: 8] = frame_byte;
            end
            else
            begin
                if (p < {1'b0, payload_length})
                begin
                    crc_next = ffc_pkg::crc_byte(crc_reg, frame_byte);
                end
                if (p < 17'(ffc_pkg::MARKER_LEN)
                    && frame_byte != ffc_pkg::marker_byte(p[2:0]))
                begin
                    match_next = 1'b0;
                end
            end
            pos_next = (pos_reg == ffc_pkg::POS_MAX) ? pos_reg : pos_reg + 17'd1;
        end
    end

    always_comb
    begin
        push = take && frame_end;
        push_data.type_chars = type_next;
        push_data.number = num_next;
        push_data.checksum = sum_next;
        push_data.crc = crc_next;
        push_data.len_short = len < 18'(ffc_pkg::HEADER_BYTES);
        push_data.len_ok = len == len_expected;
        push_data.marker_ok = match_next
            && payload_length >= 16'(ffc_pkg::MARKER_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            type_reg <= '0;
            num_reg <= '0;
            sum_reg <= '0;
            crc_reg <= ffc_pkg::CRC_INIT;
            match_reg <= 1'b1;
        end
        else if (push)
        begin
            pos_reg <= '0;
            type_reg <= '0;
            num_reg <= '0;
            sum_reg <= '0;
            crc_reg <= ffc_pkg::CRC_INIT;
            match_reg <= 1'b1;
        end
        else
        begin
            pos_reg <= pos_next;
            type_reg <= type_next;
            num_reg <= num_next;
            sum_reg <= sum_next;
            crc_reg <= crc_next;
            match_reg <= match_next;
        end
    end

endmodule

/* design/ffc_queue.sv */
module ffc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ffc_pkg::ffc_frame_t    push_data,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output ffc_pkg::ffc_frame_t    head
);

    ffc_pkg::ffc_frame_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* design/ffc_back.sv */
module ffc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  ffc_pkg::ffc_frame_t    head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             verdict,
    output logic [31:0]            frame_number
);

    logic [31:0] last_reg, last_next;
    logic        valid_reg, valid_next;
    logic [2:0]  verdict_reg, verdict_next;
    logic [31:0] number_reg, number_next;
    logic        is_data;

    assign pop = head_valid && (!valid_reg || out_ready);
    assign is_data = head.type_chars == ffc_pkg::TYPE_DATA;

    always_comb
    begin
        priority if (head.len_short)
            verdict_next = ffc_pkg::VERDICT_BAD_LENGTH;
        else if (is_data && !head.len_ok)
            verdict_next = ffc_pkg::VERDICT_BAD_LENGTH;
        else if (is_data && ~head.crc != head.checksum)
            verdict_next = ffc_pkg::VERDICT_RESEND;
        else if (is_data && head.marker_ok)
            verdict_next = ffc_pkg::VERDICT_FILE_START;
        else if (is_data)
            verdict_next = ffc_pkg::VERDICT_ACK;
        else if (head.type_chars == ffc_pkg::TYPE_DATA_END && head.number == last_reg)
            verdict_next = ffc_pkg::VERDICT_END_DATA;
        else if (head.type_chars == ffc_pkg::TYPE_END_CONN)
            verdict_next = ffc_pkg::VERDICT_END_CONN;
        else if (head.type_chars == ffc_pkg::TYPE_KEEPALIVE && head.number == 32'd0)
            verdict_next = ffc_pkg::VERDICT_KEEPALIVE;
        else
            verdict_next = ffc_pkg::VERDICT_BAD_HEADER;
    end

    always_comb
    begin
        last_next = last_reg;
        number_next = number_reg;
        valid_next = valid_reg && !out_ready;
        if (pop)
        begin
            valid_next = 1'b1;
            number_next = head.number;
            if (is_data && !head.len_short && head.len_ok)
            begin
                last_next = head.number;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg <= verdict_next;
        end
        number_reg <= number_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            last_reg <= last_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign verdict = verdict_reg;
    assign frame_number = number_reg;

endmodule

/* design/fragment_frame_checker_unit.sv */
// frame checker: takes a datagram one byte per transfer on the in channel
// (frame_byte, frame_end marks the last byte) and gives one verdict and the
// header's fragment number on the out channel per datagram
// the front parses the 10-byte header and runs the byte-wide crc-32 as bytes
// arrive, one byte per cycle while in_ready is high; the datagram's summary
// goes to a two-entry queue and the back forms the verdict into an output register
// out_valid rises once the final byte's summary has passed through the queue
// entry and then the output register; a stalled receiver can delay it
// throughput: one byte per cycle while in_ready is high, one result per cycle at most
// payload_length sits at apb byte address 0, reset value 64; write it only
// while no datagram is in flight
// reset clears the header state, crc, last data number and all valid flags
// when the receiver stalls, the output register holds, the queue fills, and
// in_ready drops only once both queue entries hold finished datagrams
`include "fragment_frame_checker_unit_assert.svh"

module fragment_frame_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [31:0] frame_number,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] payload_length_reg, payload_length_next;
    logic        q_push, q_pop, q_full, q_not_empty;
    ffc_pkg::ffc_frame_t q_in, q_head;
    logic        reg_hit;

    assign pready = 1'b1;
    assign reg_hit = paddr[2] == ffc_pkg::REG_PAYLOAD_LENGTH && paddr[1:0] == 2'b00;
    assign prdata = reg_hit ? {16'b0, payload_length_reg} : 32'b0;

    always_comb
    begin
        payload_length_next = payload_length_reg;
        if (psel && penable && pwrite && paddr[2] == ffc_pkg::REG_PAYLOAD_LENGTH)
        begin
            payload_length_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_length_reg <= ffc_pkg::PAYLOAD_LENGTH_RESET;
        end
        else
        begin
            payload_length_reg <= payload_length_next;
        end
    end

    assign in_ready = !q_full;

    ffc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_byte     (frame_byte),
        .frame_end      (frame_end),
        .payload_length (payload_length_reg),
        .push           (q_push),
        .push_data      (q_in)
    );

    ffc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ffc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_not_empty),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .verdict      (verdict),
        .frame_number (frame_number)
    );

    `FFC_ASSERT_IMPL(a_no_overflow, q_full, !q_push)
    `FFC_ASSERT_IMPL(a_pop_has_room, q_pop, q_not_empty && (!out_valid || out_ready))
    `FFC_ASSERT_NEXT(a_end_pending, in_valid && in_ready && frame_end, q_not_empty || out_valid)

endmodule
